[rtl/nsab_pkg.sv]
// Shared types and constants for the nearest-symbol-at-or-below search block.
// No dependencies; used through scoped names by every module of the block except nsab_ram.
`default_nettype none

package nsab_pkg;

  // field widths
  localparam int unsigned ADDR_VAL_W      = 16;
  localparam int unsigned SYM_NUM_W       = 6;
  localparam int unsigned ENTRY_W         = ADDR_VAL_W + SYM_NUM_W;
  localparam int unsigned TABLE_DEPTH_DEF = 64;

  // beat widths
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 24;

  // item kinds carried on s_tuser
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // read address source
  typedef enum logic [1:0] {
    RD_MID    = 2'd0,
    RD_POS_M1 = 2'd1,
    RD_POS_M2 = 2'd2
  } rd_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic    take_item;
    logic    clear_count;
    logic    set_full;
    rd_sel_t rd_sel;
    logic    shift_wr;
    logic    put_wr;
    logic    lk_step;
    logic    load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic full;
    logic pos_zero;
    logic pos_one;
    logic rd_gt_sym;
    logic lo_lt_hi;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

[rtl/nsab_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module nsab_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/nsab_ctrl.sv]
// Sequencer for insert, lookup and clear items of the symbol table.
// Depends on nsab_pkg (cmd_t, stat_t, op_t, rd_sel_t).
`default_nettype none

module nsab_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire nsab_pkg::stat_t stat,
  output nsab_pkg::cmd_t      cmd
);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_DECODE  = 7'b0000010,
    ST_INS_CMP = 7'b0000100,
    ST_INS_PUT = 7'b0001000,
    ST_LK_RD   = 7'b0010000,
    ST_LK_CMP  = 7'b0100000,
    ST_OUT     = 7'b1000000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = nsab_pkg::RD_MID;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.take_item = 1'b1;
          state_next    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (stat.op)
          nsab_pkg::OP_INSERT: begin
            if (stat.full) begin
              cmd.set_full = 1'b1;
              state_next   = ST_OUT;
            end else if (stat.pos_zero) begin
              state_next = ST_INS_PUT;
            end else begin
              cmd.rd_sel = nsab_pkg::RD_POS_M1;
              state_next = ST_INS_CMP;
            end
          end
          nsab_pkg::OP_LOOKUP: state_next = ST_LK_RD;
          nsab_pkg::OP_CLEAR: begin
            cmd.clear_count = 1'b1;
            state_next      = ST_OUT;
          end
          nsab_pkg::OP_NOP: state_next = ST_OUT;
          default: state_next = ST_OUT;
        endcase
      end
      ST_INS_CMP: begin
        // entry at pos-1 is on the read port
        if (stat.rd_gt_sym) begin
          cmd.shift_wr = 1'b1;
          if (stat.pos_one) begin
            state_next = ST_INS_PUT;
          end else begin
            cmd.rd_sel = nsab_pkg::RD_POS_M2;
          end
        end else begin
          cmd.put_wr = 1'b1;
          state_next = ST_OUT;
        end
      end
      ST_INS_PUT: begin
        cmd.put_wr = 1'b1;
        state_next = ST_OUT;
      end
      ST_LK_RD: begin
        if (stat.lo_lt_hi) begin
          cmd.rd_sel = nsab_pkg::RD_MID;
          state_next = ST_LK_CMP;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_LK_CMP: begin
        cmd.lk_step = 1'b1;
        state_next  = ST_LK_RD;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/nsab_dp.sv]
// Datapath: sorted symbol RAM, entry count, search pointers, result and output registers.
// Depends on nsab_pkg and nsab_ram.
`default_nettype none

module nsab_dp #(
  parameter int unsigned TABLE_DEPTH = nsab_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [nsab_pkg::IN_DATA_W-1:0]  s_tdata,
  input  wire logic [nsab_pkg::IN_USER_W-1:0]  s_tuser,
  input  wire nsab_pkg::cmd_t                  cmd,
  output nsab_pkg::stat_t                      stat,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [nsab_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned VAL_W  = nsab_pkg::ADDR_VAL_W;
  localparam int unsigned NUM_W  = nsab_pkg::SYM_NUM_W;

  // item registers
  nsab_pkg::op_t    op;
  logic [VAL_W-1:0] sym;
  logic [VAL_W-1:0] qry;

  // table and search state
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hi;
  logic [CNT_W:0]   lo_hi_sum;
  logic [ADDR_W-1:0] mid;

  // result registers
  logic             res_found;
  logic [NUM_W-1:0] res_num;
  logic [VAL_W-1:0] res_val;
  logic             res_full;

  // RAM ports
  logic                              ram_we;
  logic [ADDR_W-1:0]                 ram_waddr;
  logic [nsab_pkg::ENTRY_W-1:0]      ram_wdata;
  logic [ADDR_W-1:0]                 ram_raddr;
  logic [nsab_pkg::ENTRY_W-1:0]      ram_rdata;
  logic [VAL_W-1:0]                  rd_val;
  logic [NUM_W-1:0]                  new_num;

  assign lo_hi_sum = {1'b0, lo} + {1'b0, hi};
  assign mid       = ADDR_W'(lo_hi_sum >> 1);
  assign rd_val    = ram_rdata[VAL_W-1:0];
  assign new_num   = NUM_W'(count);

  // read address select
  always_comb begin
    unique case (cmd.rd_sel)
      nsab_pkg::RD_POS_M1: ram_raddr = ADDR_W'(pos - CNT_W'(1));
      nsab_pkg::RD_POS_M2: ram_raddr = ADDR_W'(pos - CNT_W'(2));
      nsab_pkg::RD_MID:    ram_raddr = mid;
      default:             ram_raddr = mid;
    endcase
  end

  // write port: shift an entry up one place, or drop the new symbol in
  assign ram_we    = cmd.shift_wr | cmd.put_wr;
  assign ram_waddr = ADDR_W'(pos);
  assign ram_wdata = cmd.shift_wr ? ram_rdata : {new_num, sym};

  nsab_ram #(
    .WIDTH (nsab_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear_count) begin
      count <= '0;
    end else if (cmd.put_wr) begin
      count <= count + CNT_W'(1);
    end
  end

  // item capture, pointers and result
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      op        <= nsab_pkg::op_t'(s_tuser);
      sym       <= s_tdata[VAL_W-1:0];
      qry       <= s_tdata[2*VAL_W-1:VAL_W];
      pos       <= count;
      lo        <= '0;
      hi        <= count;
      res_found <= 1'b0;
      res_num   <= '0;
      res_val   <= '0;
      res_full  <= 1'b0;
    end else begin
      if (cmd.set_full) begin
        res_full <= 1'b1;
      end
      if (cmd.shift_wr) begin
        pos <= pos - CNT_W'(1);
      end
      // upper-bound step: record each entry at or below the query, keeping the last
      if (cmd.lk_step) begin
        if (rd_val <= qry) begin
          lo        <= CNT_W'(mid) + CNT_W'(1);
          res_found <= 1'b1;
          res_num   <= ram_rdata[nsab_pkg::ENTRY_W-1:VAL_W];
          res_val   <= rd_val;
        end else begin
          hi <= CNT_W'(mid);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {res_full, res_val, res_num, res_found};
    end
  end

  // status
  assign stat.op        = op;
  assign stat.full      = (count == CNT_W'(TABLE_DEPTH));
  assign stat.pos_zero  = (pos == '0);
  assign stat.pos_one   = (pos == CNT_W'(1));
  assign stat.rd_gt_sym = (rd_val > sym);
  assign stat.lo_lt_hi  = (lo < hi);
  assign stat.out_free  = ~m_tvalid | m_tready;

endmodule

`default_nettype wire

[rtl/nearest_symbol_at_or_below.sv]
// Top level of the nearest-symbol-at-or-below search block.
// Depends on nsab_pkg, nsab_ctrl, nsab_dp (which holds nsab_ram).
//
// The block keeps up to TABLE_DEPTH symbols in one RAM, sorted by address value, each
// tagged with its arrival number. One item is worked on at a time; the input is ready
// again once the result is in the output register. A lookup is a binary search that
// reads one entry per pass through its read and compare states, using the RAM's
// registered read port. An insert walks down from the top of the table, moving one
// larger entry up per cycle until no larger entry is left below it; an insert into a
// full table is dropped. Entries with equal values stay in arrival order, so a lookup
// returns the latest inserted of them. There is no clearing pass after reset; the
// table comes up empty.
`default_nettype none

module nearest_symbol_at_or_below #(
  parameter int unsigned TABLE_DEPTH = nsab_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // [15:0] symbol_address, [31:16] query_address
  input  wire logic [nsab_pkg::IN_DATA_W-1:0]  s_tdata,
  // [1:0] opcode
  input  wire logic [nsab_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [0] found, [6:1] symbol_number, [22:7] symbol_value_out, [23] table_full
  output logic      [nsab_pkg::OUT_DATA_W-1:0] m_tdata
);

  nsab_pkg::cmd_t  cmd;
  nsab_pkg::stat_t stat;

  nsab_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  nsab_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

[rtl/nsab_checker.sv]
// Port-level checks for nearest_symbol_at_or_below, bound to the top level.
// Depends on nsab_pkg for beat widths.
`default_nettype none

module nsab_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [nsab_pkg::OUT_DATA_W-1:0] m_tdata
);

  // no result out of reset
  a_idle_after_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // one item at a time: input closes after a beat is taken
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input still ready after accepting a beat");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result beat changed");

  // a miss carries zero number and value
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[22:1] == '0))
    else $error("miss result with nonzero symbol fields");

  // a dropped insert never reports a hit
  a_full_no_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[23]))
    else $error("result flags both found and table full");

endmodule

bind nearest_symbol_at_or_below nsab_checker u_nsab_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

[verif/testbench.sv]
// Self-checking bench for nearest_symbol_at_or_below: a directed table, then random
// clear/insert/lookup runs scored against a behavioral model of the sorted symbol table.
// Depends on nsab_pkg and the RTL of the block.
`timescale 1ns / 100ps

module testbench;

  localparam int DEPTH        = nsab_pkg::TABLE_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 450;

  typedef struct packed {
    nsab_pkg::op_t op;
    logic [15:0]   sym;
    logic [15:0]   qry;
  } item_t;

  // laid out as on m_tdata: found in bit 0
  typedef struct packed {
    logic        full;
    logic [15:0] value;
    logic [5:0]  number;
    logic        found;
  } result_t;

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t res;
  } row_t;

  localparam result_t NO_HIT = '0;

  logic                            clk;
  logic                            rst      = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [nsab_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
  logic [nsab_pkg::IN_USER_W-1:0]  s_tuser  = nsab_pkg::OP_NOP;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [nsab_pkg::OUT_DATA_W-1:0] m_tdata;

  // model of the sorted table
  logic [15:0] tbl_value [DEPTH];
  logic [5:0]  tbl_number[DEPTH];
  int          tbl_count = 0;

  result_t     pending_results[$];
  int          fail_count    = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;

  nearest_symbol_at_or_below DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("nearest_symbol_at_or_below test failed");
    $finish;
  end

  // apply one item to the table model, return the result it yields
  function automatic result_t step_symbol_table(item_t it);
    result_t r;
    int      pos;
    r = '0;
    case (it.op)
      nsab_pkg::OP_INSERT: begin
        if (tbl_count >= DEPTH) begin
          r.full = 1'b1;
        end else begin
          // equal values stay in arrival order: go after them
          pos = tbl_count;
          while (pos > 0 && tbl_value[pos-1] > it.sym) pos--;
          for (int k = tbl_count; k > pos; k--) begin
            tbl_value[k]  = tbl_value[k-1];
            tbl_number[k] = tbl_number[k-1];
          end
          tbl_value[pos]  = it.sym;
          tbl_number[pos] = tbl_count[5:0];
          tbl_count++;
        end
      end
      nsab_pkg::OP_LOOKUP: begin
        pos = tbl_count;
        while (pos > 0 && tbl_value[pos-1] > it.qry) pos--;
        if (pos > 0) begin
          r.found  = 1'b1;
          r.number = tbl_number[pos-1];
          r.value  = tbl_value[pos-1];
        end
      end
      nsab_pkg::OP_CLEAR: tbl_count = 0;
      default: ;
    endcase
    return r;
  endfunction

  function automatic row_t mk(nsab_pkg::op_t op, logic [15:0] sym, logic [15:0] qry,
                              logic typed, result_t res);
    row_t row;
    row.it.op  = op;
    row.it.sym = sym;
    row.it.qry = qry;
    row.typed  = typed;
    row.res    = res;
    return row;
  endfunction

  function automatic result_t hit(logic [5:0] number, logic [15:0] value);
    result_t r;
    r        = '0;
    r.found  = 1'b1;
    r.number = number;
    r.value  = value;
    return r;
  endfunction

  // values that recur, so that equal values and the extremes turn up often
  function automatic logic [15:0] hot_value();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'h7FFF;
      3: return 16'h8000;
      4: return 16'hFFFE;
      5: return 16'hFFFF;
      6: return 16'h1234;
      default: return 16'hA5A5;
    endcase
  endfunction

  // random item; unused fields always carry noise
  function automatic item_t random_item(int insert_pct);
    item_t it;
    int    roll;
    int    idx;
    it.sym = 16'($urandom);
    it.qry = 16'($urandom);
    roll   = $urandom_range(99);
    if (roll < 4)
      it.op = nsab_pkg::OP_NOP;
    else if (roll < 6)
      it.op = nsab_pkg::OP_CLEAR;
    else if (roll < 6 + insert_pct * 94 / 100)
      it.op = nsab_pkg::OP_INSERT;
    else
      it.op = nsab_pkg::OP_LOOKUP;

    if (it.op == nsab_pkg::OP_INSERT && $urandom_range(99) < 30)
      it.sym = hot_value();
    if (it.op == nsab_pkg::OP_LOOKUP) begin
      roll = $urandom_range(99);
      if (tbl_count > 0 && roll < 60) begin
        // aim at a stored value or just beside it
        idx    = $urandom_range(tbl_count - 1);
        it.qry = tbl_value[idx];
        if (roll >= 40) it.qry = $urandom_range(1) ? it.qry + 16'd1 : it.qry - 16'd1;
      end else if (roll < 70) begin
        it.qry = hot_value();
      end
    end
    return it;
  endfunction

  // one input beat; valid stays up between back-to-back beats
  task automatic send_item(row_t row);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= row.it.op;
    s_tdata  <= {row.it.qry, row.it.sym};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = step_symbol_table(row.it);
    pending_results.push_back(row.typed ? row.res : predicted);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // receiver back-pressure
  always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  // score every result beat against the oldest expectation
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", m_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("found", want.found, got.found);
        check_field("symbol_number", want.number, got.number);
        check_field("symbol_value_out", want.value, got.value);
        check_field("table_full", want.full, got.full);
      end
    end
  end

  initial begin : stimulus
    row_t  directed[$];
    item_t rnd;
    int    sent;
    int    seg_len;
    int    insert_pct;

    // empty table, extremes, equal values, no-op and clear
    directed.push_back(mk(nsab_pkg::OP_LOOKUP, 16'h0000, 16'h0000, 1'b1, NO_HIT));
    directed.push_back(mk(nsab_pkg::OP_LOOKUP, 16'hFFFF, 16'hFFFF, 1'b1, NO_HIT));
    directed.push_back(mk(nsab_pkg::OP_INSERT, 16'h8000, 16'h0000, 1'b1, NO_HIT));
    directed.push_back(mk(nsab_pkg::OP_LOOKUP, 16'h0000, 16'h7FFF, 1'b1, NO_HIT));
    directed.push_back(mk(nsab_pkg::OP_LOOKUP, 16'h0000, 16'h8000, 1'b1,
                          hit(6'd0, 16'h8000)));
    directed.push_back(mk(nsab_pkg::OP_LOOKUP, 16'h0000, 16'hFFFF, 1'b1,
                          hit(6'd0, 16'h8000)));
    directed.push_back(mk(nsab_pkg::OP_INSERT, 16'h0000, 16'hFFFF, 1'b1, NO_HIT));
    directed.push_back(mk(nsab_pkg::OP_INSERT, 16'hFFFF, 16'h0000, 1'b1, NO_HIT));
    directed.push_back(mk(nsab_pkg::OP_LOOKUP, 16'hFFFF, 16'h0000, 1'b1,
                          hit(6'd1, 16'h0000)));
    directed.push_back(mk(nsab_pkg::OP_LOOKUP, 16'h0000, 16'hFFFE, 1'b0, NO_HIT));
    directed.push_back(mk(nsab_pkg::OP_LOOKUP, 16'h0000, 16'hFFFF, 1'b1,
                          hit(6'd2, 16'hFFFF)));
    directed.push_back(mk(nsab_pkg::OP_INSERT, 16'h8000, 16'h0000, 1'b0, NO_HIT));
    directed.push_back(mk(nsab_pkg::OP_LOOKUP, 16'h0000, 16'h8001, 1'b0, NO_HIT));
    directed.push_back(mk(nsab_pkg::OP_INSERT, 16'h8000, 16'hFFFF, 1'b0, NO_HIT));
    directed.push_back(mk(nsab_pkg::OP_LOOKUP, 16'hFFFF, 16'h8000, 1'b0, NO_HIT));
    directed.push_back(mk(nsab_pkg::OP_NOP, 16'hFFFF, 16'hFFFF, 1'b1, NO_HIT));
    directed.push_back(mk(nsab_pkg::OP_NOP, 16'h0000, 16'h0000, 1'b1, NO_HIT));
    directed.push_back(mk(nsab_pkg::OP_LOOKUP, 16'h0000, 16'h8000, 1'b0, NO_HIT));
    directed.push_back(mk(nsab_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1, NO_HIT));
    directed.push_back(mk(nsab_pkg::OP_LOOKUP, 16'h0000, 16'hFFFF, 1'b1, NO_HIT));
    directed.push_back(mk(nsab_pkg::OP_INSERT, 16'h1234, 16'h5555, 1'b1, NO_HIT));
    directed.push_back(mk(nsab_pkg::OP_LOOKUP, 16'hAAAA, 16'h1234, 1'b1,
                          hit(6'd0, 16'h1234)));
    directed.push_back(mk(nsab_pkg::OP_LOOKUP, 16'h0000, 16'h1233, 1'b0, NO_HIT));
    directed.push_back(mk(nsab_pkg::OP_CLEAR, 16'h0000, 16'h0000, 1'b1, NO_HIT));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[n]) send_item(directed[n]);

    // random runs, each opening on a clear; dense-insert runs overfill the table
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(4))
        0, 1:    insert_pct = 90;
        2, 3:    insert_pct = 60;
        default: insert_pct = 30;
      endcase
      seg_len = $urandom_range(110, 20);
      for (int n = 0; n < seg_len && sent < RANDOM_ITEMS; n++) begin
        case (sent * 4 / RANDOM_ITEMS)
          0: begin send_idle_pct = 0;  stall_pct = 0;  end
          1: begin send_idle_pct = 88; stall_pct = 0;  end
          2: begin send_idle_pct = 0;  stall_pct = 88; end
          default: begin send_idle_pct = 7; stall_pct = 7; end
        endcase
        if (n == 0) begin
          send_item(mk(nsab_pkg::OP_CLEAR, 16'($urandom), 16'($urandom), 1'b0, NO_HIT));
        end else begin
          rnd = random_item(insert_pct);
          send_item(mk(rnd.op, rnd.sym, rnd.qry, 1'b0, NO_HIT));
        end
        sent++;
      end
    end

    // drain, then give a slow insert time to show any stray beat
    s_tvalid <= 1'b0;
    stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (fail_count == 0)
      $display("nearest_symbol_at_or_below test passed");
    else
      $display("nearest_symbol_at_or_below test failed");
    $finish;
  end

endmodule
